>>> design/fdc_pkg.sv
`timescale 1ns / 1ps

package fdc_pkg;

	localparam int MAX_TAPS     = 2048;
	localparam int SAMPLE_W     = 24;
	localparam int COEF_W       = 24;
	localparam int TAP_CNT_W    = 12;
	localparam int COEF_IDX_W   = 11;
	localparam int ADDR_W       = $clog2(MAX_TAPS);
	localparam int CNT_W        = $clog2(MAX_TAPS + 1);
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	localparam int ACC_W        = PROD_W + CNT_W;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_COEF   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef struct packed {
		func_t                       func;
		logic signed [SAMPLE_W-1:0]  sample;
		logic [COEF_IDX_W-1:0]       coef_index;
		logic signed [COEF_W-1:0]    coef_value;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  output_sample;
		logic                        filter_active;
	} out_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} mac_ctl_t;

endpackage

>>> design/fdc_mac.sv
`timescale 1ns / 1ps

module fdc_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fdc_pkg::mac_ctl_t                     ctl,
	input  logic signed [fdc_pkg::COEF_W-1:0]     coef,
	input  logic signed [fdc_pkg::SAMPLE_W-1:0]   smp,
	output logic                                  busy,
	output logic signed [fdc_pkg::SAMPLE_W-1:0]   result
);
	import fdc_pkg::*;

	logic signed [PROD_W-1:0]   prod_s1;
	logic                       vld_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [ACC_W-1:0]    acc_shr;
	logic [ACC_W-SAMPLE_W:0]    acc_top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s1 <= coef * smp;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	// round half up, drop the coefficient fraction bits, then saturate
	assign acc_rnd = acc_q + (ACC_W'(1) << (COEF_W - 2));
	assign acc_shr = acc_rnd >>> (COEF_W - 1);
	assign acc_top = acc_shr[ACC_W-1:SAMPLE_W-1];

	always_comb begin
		if ((&acc_top) || !(|acc_top)) begin
			result = acc_shr[SAMPLE_W-1:0];
		end else if (acc_shr[ACC_W-1]) begin
			result = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	assign busy = vld_s1;

endmodule

>>> design/fir_direct_convolution.sv
`timescale 1ns / 1ps
// Sample path: a sample transaction with n = min(tap_count, samples since clear) active taps
//   passes S_RUN, S_DRAIN and S_ROUND before out_valid (only S_ROUND when n is zero).
// Throughput: one tap per cycle through the shared multiply-accumulate; after a sample the
//   next transaction is accepted only once S_ROUND has registered the result, which waits
//   while the previous result is held; coefficient and clear transactions stay in S_IDLE.
// Reset: control clears at once, then S_CLEAR zeroes every coefficient entry, in_ready low.

module fir_direct_convolution (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fdc_pkg::TAP_CNT_W-1:0]      cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  fdc_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output fdc_pkg::out_t                      out_data
);
	import fdc_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_RUN   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_ROUND = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [TAP_CNT_W-1:0]       tap_count_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [ADDR_W-1:0]          wp_q;
	logic [CNT_W-1:0]           vc_q;
	logic [CNT_W-1:0]           n_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ADDR_W-1:0]          pos_q;
	logic                       rd_vld_s1;
	logic                       out_valid_q;
	out_t                       out_q;

	logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic signed [COEF_W-1:0]   coef_rd_q;
	logic signed [SAMPLE_W-1:0] hist_rd_q;

	logic                       in_xfer;
	logic                       coef_we;
	logic [ADDR_W-1:0]          coef_wa;
	logic signed [COEF_W-1:0]   coef_wd;
	logic                       hist_we;
	logic                       rd_en;
	logic [CNT_W-1:0]           taps;
	logic [CNT_W-1:0]           vc_next;
	logic [CNT_W-1:0]           n_next;
	logic                       out_free;
	mac_ctl_t                   mac_ctl;
	logic                       mac_busy;
	logic signed [SAMPLE_W-1:0] mac_result;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign taps    = (32'(tap_count_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_q);
	assign vc_next = (vc_q == CNT_W'(MAX_TAPS)) ? vc_q : vc_q + 1'b1;
	assign n_next  = (taps < vc_next) ? taps : vc_next;

	assign hist_we = in_xfer && (in_data.func == FUNC_SAMPLE);
	assign rd_en   = (state_q == S_RUN);

	always_comb begin
		coef_we = 1'b0;
		coef_wa = clr_q;
		coef_wd = '0;
		if (state_q == S_CLEAR) begin
			coef_we = 1'b1;
		end else if (in_xfer && (in_data.func == FUNC_COEF)
				&& (32'(in_data.coef_index) < MAX_TAPS)) begin
			coef_we = 1'b1;
			coef_wa = ADDR_W'(in_data.coef_index);
			coef_wd = in_data.coef_value;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_wd;
		end
		if (rd_en) begin
			coef_rd_q <= coef_mem[cnt_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= in_data.sample;
		end
		if (rd_en) begin
			hist_rd_q <= hist_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= '0;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			vc_q        <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_valid_q && out_ready && (state_q != S_ROUND)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MAX_TAPS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						case (in_data.func)
							FUNC_SAMPLE: begin
								vc_q  <= vc_next;
								n_q   <= n_next;
								cnt_q <= '0;
								pos_q <= wp_q;
								wp_q  <= (wp_q == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
								state_q <= (n_next == '0) ? S_ROUND : S_RUN;
							end
							FUNC_CLEAR: begin
								vc_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					// walk the coefficients up and the history back from the newest sample
					cnt_q <= cnt_q + 1'b1;
					pos_q <= (pos_q == '0) ? ADDR_W'(MAX_TAPS - 1) : pos_q - 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_s1 && !mac_busy) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					// hold until the output slot is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_ROUND) && out_free) begin
			out_q.output_sample <= mac_result;
			out_q.filter_active <= (tap_count_q != '0);
		end
	end

	assign mac_ctl.clr = hist_we;
	assign mac_ctl.vld = rd_vld_s1;

	fdc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_rd_q),
		.smp    (hist_rd_q),
		.busy   (mac_busy),
		.result (mac_result)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register is not one-hot");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q < n_q) && (n_q != '0))
		else $error("tap counter ran past the active tap count");

	a_read_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == S_RUN))
		else $error("memory read outside the tap loop");

	a_round_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (!rd_vld_s1 && !mac_busy))
		else $error("rounding while products are still in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_q))
		else $error("pending result was overwritten");

endmodule

>>> dv/fir_output_checker.sv
`timescale 1ns / 1ps

module fir_output_checker
	import fdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TAP_CNT_W-1:0]  cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_t                  out_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

	logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
	logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
	int unsigned                wr_ptr;
	int unsigned                hist_count;
	logic [TAP_CNT_W-1:0]       taps_cfg;
	out_t                       expected_outputs [$];
	int                         error_count = 0;

	assign mismatches = error_count;

	// Enter one sample into the history and return the filtered value.
	function automatic out_t convolve_sample(input logic signed [SAMPLE_W-1:0] x);
		int unsigned taps;
		int unsigned n;
		int unsigned pos;
		int unsigned m;
		longint      acc;
		longint      rounded;
		out_t        res;
		taps = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
		history[wr_ptr] = x;
		if (hist_count < MAX_TAPS)
			hist_count++;
		n = (taps < hist_count) ? taps : hist_count;
		acc = 0;
		pos = wr_ptr;
		for (m = 0; m < n; m++) begin
			acc += longint'(coefs[m]) * longint'(history[pos]);
			pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
		end
		wr_ptr = (wr_ptr == MAX_TAPS - 1) ? 0 : wr_ptr + 1;
		// Round half up, drop the coefficient fraction bits, then saturate.
		rounded = (acc + (longint'(1) <<< (COEF_W - 2))) >>> (COEF_W - 1);
		if (rounded > OUT_MAX)
			rounded = OUT_MAX;
		else if (rounded < OUT_MIN)
			rounded = OUT_MIN;
		res.output_sample = rounded[SAMPLE_W-1:0];
		res.filter_active = (taps_cfg != '0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		out_t want;
		out_t got;
		if (!arst_n) begin
			foreach (coefs[i])
				coefs[i] = '0;
			foreach (history[i])
				history[i] = '0;
			wr_ptr     = 0;
			hist_count = 0;
			taps_cfg   = '0;
			expected_outputs.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				taps_cfg = cfg_wdata;
			if (in_valid && in_ready) begin
				case (in_data.func)
					FUNC_SAMPLE: expected_outputs.push_back(convolve_sample(in_data.sample));
					FUNC_COEF: begin
						if (in_data.coef_index < MAX_TAPS)
							coefs[in_data.coef_index] = in_data.coef_value;
					end
					FUNC_CLEAR: hist_count = 0;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_outputs.size() == 0) begin
					$error("output transaction with nothing expected: output_sample %0d, filter_active %0b",
						got.output_sample, got.filter_active);
					error_count++;
				end else begin
					want = expected_outputs.pop_front();
					if (got.output_sample !== want.output_sample) begin
						$error("output_sample: expected %0d, got %0d",
							want.output_sample, got.output_sample);
						error_count++;
					end
					if (got.filter_active !== want.filter_active) begin
						$error("filter_active: expected %0b, got %0b",
							want.filter_active, got.filter_active);
						error_count++;
					end
				end
			end
			outstanding <= expected_outputs.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fdc_pkg::*;

	localparam int         CYCLE_LIMIT    = 1000000;
	localparam int         SETTLE_CYCLES  = 16;
	localparam int         DRAIN_CYCLES   = MAX_TAPS + 64;
	localparam int         RX_HOLD_CYCLES = 600;
	localparam logic [1:0] FUNC_RESERVED  = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] S_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   C_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0]   C_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   C_HALF = {2'b01, {(COEF_W-2){1'b0}}};
	localparam logic [TAP_CNT_W-1:0]       TAPS_ALL_ONES = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TAP_CNT_W-1:0]  cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;

	int mismatches;
	int outstanding;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int rx_hold_reqs  = 0;
	int rx_hold_taken = 0;
	int rx_hold_left  = 0;
	int cycle_count   = 0;

	fir_direct_convolution dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	fir_output_checker output_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Result side: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (rx_hold_taken != rx_hold_reqs) begin
			rx_hold_taken = rx_hold_reqs;
			rx_hold_left  = RX_HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic in_t op_item(input func_t f, input logic signed [SAMPLE_W-1:0] x,
			input logic [COEF_IDX_W-1:0] idx, input logic signed [COEF_W-1:0] h);
		in_t item;
		item.func       = f;
		item.sample     = x;
		item.coef_index = idx;
		item.coef_value = h;
		return item;
	endfunction

	function automatic in_t random_item();
		in_t         item;
		int unsigned pick;
		pick            = $urandom_range(99);
		item.sample     = SAMPLE_W'($urandom);
		item.coef_index = COEF_IDX_W'($urandom);
		item.coef_value = COEF_W'($urandom);
		if (pick < 70) begin
			item.func = FUNC_SAMPLE;
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(2))
					0: item.sample = S_MAX;
					1: item.sample = S_MIN;
					default: item.sample = '0;
				endcase
			end
		end else if (pick < 88) begin
			item.func = FUNC_COEF;
			// keep most writes inside the first 64 coefficients
			if ($urandom_range(3) != 0)
				item.coef_index = COEF_IDX_W'($urandom_range(63));
			if ($urandom_range(1) == 0)
				item.coef_value = COEF_W'($urandom_range(131071) - 65536);
		end else if (pick < 94) begin
			item.func = FUNC_CLEAR;
		end else begin
			item.func = func_t'(FUNC_RESERVED);
		end
		return item;
	endfunction

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_taps(input logic [TAP_CNT_W-1:0] taps);
		wait_drained();
		// coefficient and clear transactions leave no result behind; let them retire
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= taps;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 38;
		rx_idle_pct = 51;
		set_taps(4);

		// coefficients still zero after reset
		send_item(op_item(FUNC_SAMPLE, S_MAX, 0, 0));
		// two full-scale negative taps drive the sum past the positive rail
		send_item(op_item(FUNC_COEF, 0, 0, C_MIN));
		send_item(op_item(FUNC_COEF, 0, 1, C_MIN));
		send_item(op_item(FUNC_SAMPLE, S_MIN, 0, 0));
		send_item(op_item(FUNC_SAMPLE, S_MIN, 0, 0));
		send_item(op_item(FUNC_SAMPLE, S_MAX, 0, 0));
		send_item(op_item(FUNC_CLEAR, 0, 0, 0));
		send_item(op_item(FUNC_SAMPLE, S_MAX, 0, 0));
		// full-scale positive taps against negative samples hit the negative rail
		send_item(op_item(FUNC_COEF, 0, 0, C_MAX));
		send_item(op_item(FUNC_COEF, 0, 1, C_MAX));
		send_item(op_item(FUNC_SAMPLE, S_MIN, 0, 0));
		send_item(op_item(FUNC_SAMPLE, S_MIN, 0, 0));
		send_item(op_item(FUNC_COEF, 0, COEF_IDX_W'(MAX_TAPS - 1), C_MAX));
		// half-LSB ties: +0.5 rounds up, -0.5 rounds to zero
		send_item(op_item(FUNC_CLEAR, 0, 0, 0));
		send_item(op_item(FUNC_COEF, 0, 0, C_HALF));
		send_item(op_item(FUNC_COEF, 0, 1, 0));
		send_item(op_item(FUNC_SAMPLE, 1, 0, 0));
		send_item(op_item(FUNC_SAMPLE, -1, 0, 0));
		send_item(op_item(func_t'(FUNC_RESERVED), S_MAX, 5, C_MAX));
		send_item(op_item(FUNC_SAMPLE, 0, 0, 0));

		set_taps(8);
		repeat (40) send_item(random_item());
		set_taps(0);
		repeat (20) send_item(random_item());

		tx_idle_pct = 51;
		rx_idle_pct = 38;
		set_taps(1);
		repeat (30) send_item(random_item());
		set_taps(37);
		repeat (40) send_item(random_item());

		// hold the result side off while samples keep coming
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_taps(16);
		rx_hold_reqs++;
		repeat (30) send_item(op_item(FUNC_SAMPLE, SAMPLE_W'($urandom),
			COEF_IDX_W'($urandom), COEF_W'($urandom)));

		set_taps(100);
		repeat (50) send_item(random_item());

		// spread coefficients over the whole table, then clamp oversized tap counts
		set_taps(0);
		repeat (30) send_item(op_item(FUNC_SAMPLE, SAMPLE_W'($urandom), 0, 0));
		for (int i = 0; i < MAX_TAPS; i += 89)
			send_item(op_item(FUNC_COEF, 0, COEF_IDX_W'(i),
				COEF_W'($urandom_range(131071) - 65536)));
		send_item(op_item(FUNC_COEF, 0, COEF_IDX_W'(MAX_TAPS - 1), C_MIN));

		set_taps(TAP_CNT_W'(MAX_TAPS));
		repeat (4) send_item(op_item(FUNC_SAMPLE, SAMPLE_W'($urandom), 0, 0));
		set_taps(TAPS_ALL_ONES);
		repeat (4) send_item(op_item(FUNC_SAMPLE, SAMPLE_W'($urandom), 0, 0));
		set_taps(TAP_CNT_W'(MAX_TAPS - 1));
		repeat (3) send_item(op_item(FUNC_SAMPLE, SAMPLE_W'($urandom), 0, 0));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
design/fdc_pkg.sv
design/fdc_mac.sv
design/fir_direct_convolution.sv
dv/fir_output_checker.sv
dv/testbench.sv
